// ===== rtl/fsa_pkg.sv =====
package fsa_pkg;

	localparam int TableDepthDef = 64;
	localparam int SampleBitsDef = 16;
	localparam int LimitBits = 7;
	localparam int CountBits = 32;
	localparam int SumBits = 48;
	localparam int SqBits = 63;

	// One queued word between the front end and the back end.
	typedef struct packed {
		logic        absent;
		logic [23:0] sample;
	} fsa_word_t;

endpackage

// ===== rtl/field_stats_accumulator.sv =====
// Channel | Direction | Handshake        | Payload
// input   | in        | push / full      | sample, absent
// result  | out       | empty / pop      | eleven statistics fields
// config  | in        | cfg_valid/ready  | cfg_data (max_distinct)
// A missing word is counted straight from the queue; a present word is squared and
// then searched one table key at a time through the single table read port.
// Reset clears the counts, sums and table fill, sets min and max to their extremes,
// sets the limit to 64 and enables distinct counting.
// The two-word input queue accepts until full while a result waits for pop.
module field_stats_accumulator #(
	parameter int TABLE_DEPTH = fsa_pkg::TableDepthDef,
	parameter int SAMPLE_BITS = fsa_pkg::SampleBitsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic absent,
	output logic empty,
	input  logic pop,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [fsa_pkg::LimitBits-1:0] cfg_data,
	output logic [fsa_pkg::CountBits-1:0] missing_count,
	output logic [fsa_pkg::CountBits-1:0] present_count,
	output logic [fsa_pkg::CountBits-1:0] positive_count,
	output logic [fsa_pkg::CountBits-1:0] negative_count,
	output logic signed [fsa_pkg::SumBits-1:0] running_sum,
	output logic [fsa_pkg::SqBits-1:0] running_sum_squares,
	output logic signed [SAMPLE_BITS-1:0] min_seen,
	output logic signed [SAMPLE_BITS-1:0] max_seen,
	output logic [fsa_pkg::LimitBits-1:0] distinct_count,
	output logic distinct_active,
	output logic [fsa_pkg::CountBits-1:0] value_count
);
	import fsa_pkg::*;

	logic [LimitBits-1:0] max_distinct_q;
	fsa_word_t in_word, q_word;
	logic q_valid, q_take, res_valid;

	assign cfg_ready = 1'b1;
	assign empty = !res_valid;
	assign in_word.absent = absent;
	assign in_word.sample = 24'(unsigned'(sample));

	// Limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_distinct_q <= LimitBits'(64);
		else if (cfg_valid && cfg_ready) max_distinct_q <= cfg_data;
	end

	fsa_front u_front (
		.clk, .arst_n, .push, .full, .in_word,
		.q_valid, .q_take, .q_word
	);

	fsa_back #(.TABLE_DEPTH(TABLE_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk, .arst_n, .max_distinct_q, .q_valid, .q_take, .q_word,
		.res_valid, .res_pop(pop), .missing_count, .present_count,
		.positive_count, .negative_count, .running_sum, .running_sum_squares,
		.min_seen, .max_seen, .distinct_count, .distinct_active, .value_count
	);

	// The table never holds more entries than its depth.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		32'(distinct_count) <= TABLE_DEPTH) else $error("fill above depth");
	// Counting, once stopped, stays stopped.
	a_stop: assert property (@(posedge clk) disable iff (!arst_n)
		!u_back.counting_q |=> !u_back.counting_q) else $error("counting restarted");
	// A popped result leaves the output empty on the next cycle.
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty) |=> empty) else $error("result repeated");
endmodule

// ===== rtl/fsa_front.sv =====
// Front end: accepts words into a two-entry queue.
module fsa_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  fsa_pkg::fsa_word_t in_word,
	output logic              q_valid,
	input  logic              q_take,
	output fsa_pkg::fsa_word_t q_word
);
	import fsa_pkg::*;

	fsa_word_t mem_q [2];
	logic [1:0] wr_q, rd_q;
	logic [1:0] cnt_q;
	logic do_push;

	assign full = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign do_push = push && !full;
	assign q_word = mem_q[rd_q[0]];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q[0]] <= in_word;
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 2'd1;
			if (q_take) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, q_take};
		end
	end
endmodule

// ===== rtl/fsa_back.sv =====
// Back end: statistics update and sequential distinct-value search.
module fsa_back #(
	parameter int TABLE_DEPTH = fsa_pkg::TableDepthDef,
	parameter int SAMPLE_BITS = fsa_pkg::SampleBitsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fsa_pkg::LimitBits-1:0]   max_distinct_q,
	input  logic                            q_valid,
	output logic                            q_take,
	input  fsa_pkg::fsa_word_t              q_word,
	output logic                            res_valid,
	input  logic                            res_pop,
	output logic [fsa_pkg::CountBits-1:0]   missing_count,
	output logic [fsa_pkg::CountBits-1:0]   present_count,
	output logic [fsa_pkg::CountBits-1:0]   positive_count,
	output logic [fsa_pkg::CountBits-1:0]   negative_count,
	output logic signed [fsa_pkg::SumBits-1:0] running_sum,
	output logic [fsa_pkg::SqBits-1:0]      running_sum_squares,
	output logic signed [SAMPLE_BITS-1:0]   min_seen,
	output logic signed [SAMPLE_BITS-1:0]   max_seen,
	output logic [fsa_pkg::LimitBits-1:0]   distinct_count,
	output logic                            distinct_active,
	output logic [fsa_pkg::CountBits-1:0]   value_count
);
	import fsa_pkg::*;

	localparam int IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FillBits = $clog2(TABLE_DEPTH + 1);
	localparam int LimW = (FillBits > LimitBits) ? FillBits : LimitBits;
	localparam logic [SAMPLE_BITS-1:0] MinInit = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] MaxInit = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic [2:0] StIdle   = 3'd0;
	localparam logic [2:0] StSquare = 3'd1;
	localparam logic [2:0] StRead   = 3'd2;
	localparam logic [2:0] StCmp    = 3'd3;
	localparam logic [2:0] StDone   = 3'd4;

	logic [2:0] state_q;
	logic [SAMPLE_BITS-1:0] key_q;
	logic signed [2*SAMPLE_BITS-1:0] sq_q;
	logic [FillBits-1:0] fill_q;
	logic [FillBits-1:0] idx_q;
	logic counting_q;
	logic [SAMPLE_BITS-1:0] keys_mem [TABLE_DEPTH];
	logic [CountBits-1:0] cnts_mem [TABLE_DEPTH];
	logic [SAMPLE_BITS-1:0] rd_key_q;
	logic [CountBits-1:0] rd_cnt_q;
	logic [LimW-1:0] lim;
	logic [SqBits:0] sq_sum;
	logic signed [SAMPLE_BITS-1:0] s;
	logic [CountBits-1:0] inc_cnt;

	// Effective limit clamps to the table depth.
	always_comb begin
		if ({{(LimW-LimitBits){1'b0}}, max_distinct_q} > LimW'(TABLE_DEPTH))
			lim = LimW'(TABLE_DEPTH);
		else
			lim = LimW'(max_distinct_q);
	end

	assign s = signed'(q_word.sample[SAMPLE_BITS-1:0]);
	assign sq_sum = {1'b0, running_sum_squares} + (SqBits+1)'(unsigned'(sq_q));
	assign inc_cnt = (&rd_cnt_q) ? rd_cnt_q : rd_cnt_q + 1'b1;
	assign q_take = (state_q == StIdle) && q_valid && !res_valid;
	assign distinct_count = LimitBits'(fill_q);
	assign distinct_active = counting_q && (lim != '0);

	// Table memory, one read port registered.
	always_ff @(posedge clk) begin
		rd_key_q <= keys_mem[idx_q[IdxBits-1:0]];
		rd_cnt_q <= cnts_mem[idx_q[IdxBits-1:0]];
		if (state_q == StCmp && counting_q) begin
			if (idx_q < fill_q && rd_key_q == key_q)
				cnts_mem[idx_q[IdxBits-1:0]] <= inc_cnt;
			else if (idx_q >= fill_q) begin
				keys_mem[idx_q[IdxBits-1:0]] <= key_q;
				cnts_mem[idx_q[IdxBits-1:0]] <= CountBits'(1);
			end
		end
	end

	// Sequencer: square, then search the table one key at a time, with a read and a compare state per key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			res_valid <= 1'b0;
			missing_count <= '0;
			present_count <= '0;
			positive_count <= '0;
			negative_count <= '0;
			running_sum <= '0;
			running_sum_squares <= '0;
			min_seen <= MinInit;
			max_seen <= MaxInit;
			counting_q <= 1'b1;
			fill_q <= '0;
			idx_q <= '0;
			value_count <= '0;
			key_q <= '0;
			sq_q <= '0;
		end else begin
			if (res_valid && res_pop) res_valid <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (q_take) begin
						value_count <= '0;
						if (q_word.absent) begin
							if (!(&missing_count)) missing_count <= missing_count + 1'b1;
							res_valid <= 1'b1;
						end else begin
							key_q <= q_word.sample[SAMPLE_BITS-1:0];
							sq_q <= s * s;
							if (!(&present_count)) present_count <= present_count + 1'b1;
							running_sum <= running_sum + SumBits'(s);
							if (s > 0 && !(&positive_count))
								positive_count <= positive_count + 1'b1;
							if (s < 0 && !(&negative_count))
								negative_count <= negative_count + 1'b1;
							if (s < min_seen) min_seen <= s;
							if (s > max_seen) max_seen <= s;
							state_q <= StSquare;
						end
					end
				end
				StSquare: begin
					running_sum_squares <= sq_sum[SqBits] ? {SqBits{1'b1}} : sq_sum[SqBits-1:0];
					idx_q <= '0;
					if (!counting_q || lim == '0) begin
						state_q <= StDone;
					end else if (LimW'(fill_q) >= lim) begin
						counting_q <= 1'b0;
						fill_q <= '0;
						state_q <= StDone;
					end else begin
						state_q <= StRead;
					end
				end
				StRead: state_q <= StCmp;
				StCmp: begin
					if (idx_q < fill_q && rd_key_q == key_q) begin
						value_count <= inc_cnt;
						state_q <= StDone;
					end else if (idx_q >= fill_q) begin
						value_count <= CountBits'(1);
						fill_q <= fill_q + 1'b1;
						state_q <= StDone;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= StRead;
					end
				end
				StDone: begin
					res_valid <= 1'b1;
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule
